>>> rtl/core/adgf_pkg.sv
// Shared types, constants and helpers for the alpha disc glow filter.
`timescale 1ns / 1ps
`default_nettype none
package adgf_pkg;

  localparam int MAX_WIDTH = 256;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int SIZE_W    = 9;
  localparam int ROW_W     = SIZE_W + 1;
  localparam int PIX_W     = 8;
  localparam int CSUM_W    = 14;
  localparam int TOT_W     = 16;
  localparam int X_W       = 15;
  localparam int QDEPTH    = 8;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = QPTR_W + 1;

  // 2*S >= 256*75 saturates; below that floor(x/75) = (x*M) >> SH
  localparam int SAT_LIMIT = 256 * 75 / 2;
  localparam int RECIP_SH  = 21;
  localparam int RECIP_M   = (2 ** RECIP_SH + 74) / 75;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;

  typedef struct packed {
    logic [4:0][CSUM_W-1:0] csum;
    logic                   last;
  } adgf_entry_t;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] r;
    r = v;
    if (v < SIZE_W'(5)) r = SIZE_W'(5);
    else if (v > SIZE_W'(MAX_WIDTH)) r = SIZE_W'(MAX_WIDTH);
    return r;
  endfunction

  function automatic logic [3:0] disc_weight(input int dy, input int dx);
    logic [3:0] r;
    r = 4'd9;
    if ((dy == 0 || dy == 4) && (dx == 0 || dx == 4)) r = 4'd1;
    else if ((dy == 0 || dy == 4) && (dx == 1 || dx == 3)) r = 4'd7;
    else if ((dx == 0 || dx == 4) && (dy == 1 || dy == 3)) r = 4'd7;
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/adgf_ram.sv
// Generic single-write, registered-read RAM (read returns old data on collision).
`timescale 1ns / 1ps
`default_nettype none
module adgf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> rtl/core/adgf_front.sv
// Front end: frame position tracking, line store, 5x5 window and column sums.
`timescale 1ns / 1ps
`default_nettype none
module adgf_front import adgf_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              take,
  input  wire logic              cmd,
  input  wire logic [PIX_W-1:0]  alpha,
  input  wire logic              restart,
  input  wire logic [SIZE_W-1:0] w,
  input  wire logic [SIZE_W-1:0] h,
  output logic                   push,
  output adgf_entry_t            entry,
  output logic [1:0]             busy
);
  logic [SIZE_W-1:0] col;
  logic [ROW_W-1:0]  row;
  logic [SIZE_W-1:0] xo;
  logic [SIZE_W-1:0] yo;

  logic [SIZE_W-1:0] c;
  logic [SIZE_W-1:0] c_inc;
  logic [PIX_W-1:0]  sample;
  logic              emit;
  logic              last;
  logic [4:0]        cmask;
  logic [4:0]        rmask;

  logic              f0_valid, f0_emit, f0_last;
  logic [PIX_W-1:0]  f0_sample;
  logic [1:0]        f0_slot;
  logic [4:0]        f0_cmask, f0_rmask;
  logic [PIX_W-1:0]  ram_q [4];

  logic              f2_valid, f2_last;
  logic [4:0]        f2_cmask, f2_rmask;
  logic [PIX_W-1:0]  win [5][5];

  always_comb begin
    c      = (col >= w) ? '0 : col;
    c_inc  = c + SIZE_W'(1);
    sample = (cmd == CMD_DRAIN) ? '0 : alpha;
    emit   = (row > ROW_W'(2)) || (row == ROW_W'(2) && c >= SIZE_W'(2));
    last   = (xo == w - SIZE_W'(1)) && (yo == h - SIZE_W'(1));
    // tap validity around the output centre
    cmask  = {(xo + SIZE_W'(2)) < w, (xo + SIZE_W'(1)) < w, 1'b1,
              xo >= SIZE_W'(1), xo >= SIZE_W'(2)};
    rmask  = {(yo + SIZE_W'(2)) < h, (yo + SIZE_W'(1)) < h, 1'b1,
              yo >= SIZE_W'(1), yo >= SIZE_W'(2)};
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col <= '0;
      row <= '0;
      xo  <= '0;
      yo  <= '0;
    end else if (take) begin
      if (emit && last) begin
        col <= '0;
        row <= '0;
        xo  <= '0;
        yo  <= '0;
      end else begin
        if (c_inc >= w) begin
          col <= '0;
          row <= row + ROW_W'(1);
        end else begin
          col <= c_inc;
        end
        if (emit) begin
          if (xo + SIZE_W'(1) >= w) begin
            xo <= '0;
            yo <= yo + SIZE_W'(1);
          end else begin
            xo <= xo + SIZE_W'(1);
          end
        end
      end
    end
  end

  for (genvar i = 0; i < 4; i++) begin : g_line
    adgf_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_ram (
      .clk   (clk),
      .we    (take && row[1:0] == 2'(i)),
      .waddr (c[COL_W-1:0]),
      .wdata (sample),
      .raddr (c[COL_W-1:0]),
      .rdata (ram_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f0_valid <= 1'b0;
      f2_valid <= 1'b0;
    end else begin
      f0_valid <= take;
      f2_valid <= f0_valid && f0_emit;
    end
  end

  always_ff @(posedge clk) begin
    f0_emit   <= emit;
    f0_last   <= last;
    f0_sample <= sample;
    f0_slot   <= row[1:0];
    f0_cmask  <= cmask;
    f0_rmask  <= rmask;
    f2_last   <= f0_last;
    f2_cmask  <= f0_cmask;
    f2_rmask  <= f0_rmask;
    if (f0_valid) begin
      // advance the window one column; oldest row first
      for (int k = 0; k < 4; k++) win[k] <= win[k+1];
      for (int k = 0; k < 4; k++) win[4][k] <= ram_q[2'(f0_slot + 2'(k))];
      win[4][4] <= f0_sample;
    end
  end

  always_comb begin
    entry.last = f2_last;
    for (int dx = 0; dx < 5; dx++) begin
      entry.csum[dx] = '0;
      for (int dy = 0; dy < 5; dy++) begin
        if (f2_cmask[dx] && f2_rmask[dy])
          entry.csum[dx] = entry.csum[dx]
                         + CSUM_W'(win[dx][dy]) * CSUM_W'(disc_weight(dy, dx));
      end
    end
  end

  assign push = f2_valid;
  assign busy = {1'b0, f0_valid} + {1'b0, f2_valid};
endmodule
`default_nettype wire

>>> rtl/core/adgf_queue.sv
// Short FIFO of column sums between front and back ends.
`timescale 1ns / 1ps
`default_nettype none
module adgf_queue import adgf_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  input  wire adgf_entry_t din,
  input  wire logic        pop,
  output adgf_entry_t      dout,
  output logic             nonempty,
  output logic [QCNT_W-1:0] count
);
  adgf_entry_t       slots [QDEPTH];
  logic [QPTR_W-1:0] wptr, rptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + QPTR_W'(1);
      if (pop)  rptr <= rptr + QPTR_W'(1);
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= din;
  end

  assign dout     = slots[rptr];
  assign nonempty = (count != '0);
endmodule
`default_nettype wire

>>> rtl/core/adgf_back.sv
// Back end: total, scale by 2/75 with saturation, output register.
`timescale 1ns / 1ps
`default_nettype none
module adgf_back import adgf_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire adgf_entry_t      din,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [PIX_W-1:0]      out_alpha,
  output logic                  out_last
);
  logic             b1_valid, b1_sat, b1_last;
  logic [X_W-1:0]   b1_x;
  logic [TOT_W-1:0] total;
  logic             o_adv;
  logic [2*X_W-1:0] prod;

  assign o_adv    = !out_valid || out_ready;
  assign in_ready = !b1_valid || o_adv;

  always_comb begin
    total = '0;
    for (int i = 0; i < 5; i++) total = total + TOT_W'(din.csum[i]);
  end

  assign prod = (2*X_W)'(b1_x) * (2*X_W)'(RECIP_M);

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) b1_valid <= in_valid;
      if (o_adv)    out_valid <= b1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      b1_x    <= X_W'({total, 1'b0});
      b1_sat  <= total >= TOT_W'(SAT_LIMIT);
      b1_last <= din.last;
    end
    if (o_adv && b1_valid) begin
      out_alpha <= b1_sat ? '1 : prod[RECIP_SH +: PIX_W];
      out_last  <= b1_last;
    end
  end
endmodule
`default_nettype wire

>>> rtl/core/alpha_disc_glow_filter_unit.sv
// Top level of the alpha disc glow filter.
//
//  channel | direction | handshake             | payload
//  s_axis  | in        | s_tvalid / s_tready   | tdata = alpha_in, tuser = cmd
//  m_axis  | out       | m_tvalid / m_tready   | tdata = alpha_out, tlast = last_pixel
//  cfg     | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One beat per cycle while s_tready is high; the result of the beat that completes
// a window passes the line-store read, window, queue, scaling and output registers,
// unstalled given an empty queue and a ready output (sums and total combinational).
// The result for a pixel needs 2*W+2 further beats, so drains flush a frame.
// Reset sets 69x69 and starts a new frame; a width or height write restarts the frame.
// Input stalls only when the eight-entry queue plus in-flight beats are full.
`timescale 1ns / 1ps
`default_nettype none
module alpha_disc_glow_filter_unit import adgf_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [PIX_W-1:0]  s_tdata,   // [7:0] alpha_in
  input  wire logic              s_tuser,   // [0] cmd
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic      [PIX_W-1:0]  m_tdata,   // [7:0] alpha_out
  output logic                   m_tlast,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [SIZE_W-1:0] cfg_data
);
  logic [SIZE_W-1:0] frame_width, frame_height;
  logic              take, restart, push, pop, nonempty, b_ready;
  logic [1:0]        busy;
  logic [QCNT_W-1:0] count;
  adgf_entry_t       f_entry, q_entry;

  assign cfg_ready = 1'b1;
  assign restart   = cfg_valid && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= SIZE_W'(69);
      frame_height <= SIZE_W'(69);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WIDTH:  frame_width  <= cfg_data;
        REG_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // hold input back unless every beat in flight has a queue slot
  assign s_tready = ((QCNT_W+1)'(count) + (QCNT_W+1)'(busy)) < (QCNT_W+1)'(QDEPTH);
  assign take     = s_tvalid && s_tready;
  assign pop      = nonempty && b_ready;

  adgf_front u_front (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .cmd     (s_tuser),
    .alpha   (s_tdata),
    .restart (restart),
    .w       (clamp_size(frame_width)),
    .h       (clamp_size(frame_height)),
    .push    (push),
    .entry   (f_entry),
    .busy    (busy)
  );

  adgf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .din      (f_entry),
    .pop      (pop),
    .dout     (q_entry),
    .nonempty (nonempty),
    .count    (count)
  );

  adgf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (nonempty),
    .din       (q_entry),
    .in_ready  (b_ready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_alpha (m_tdata),
    .out_last  (m_tlast)
  );
endmodule
`default_nettype wire
